FILE: sv/rna_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rna_pkg: shared types and codes of the rational number alu
// Request and result layouts, operation and status codes, controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rna_pkg;

	localparam int unsigned WIDTH_DEF = 32;
	localparam int unsigned DIV_STEPS = 32;

	// operation codes
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_CMP = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVF      = 2'd2;

	// compare outcome codes
	localparam logic [1:0] ORD_LT = 2'd0;
	localparam logic [1:0] ORD_EQ = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic signed [31:0] res_den;
		logic [1:0]         order;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_GCD,
		S_DIVA,
		S_DIVSW,
		S_DIVB,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_SUM,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		PR_0,
		PR_1,
		PR_2
	} prod_t;

	typedef struct packed {
		logic  load;
		logic  gcd_step;
		logic  div_init;
		logic  div_sel_b;
		logic  div_step;
		logic  mul_go;
		prod_t mul_idx;
		logic  sum_go;
		logic  fin_go;
	} ctl_cmd_t;

	typedef struct packed {
		logic early;
		logic addsub;
		logic gcd_done;
	} ctl_stat_t;

endpackage
`default_nettype wire

FILE: sv/rna_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rna_ctrl: sequencer of the rational number alu
// Issues datapath commands for one request: gcd and two divisions (add/sub),
// three products, sum and result stage, or the result stage alone if early.
// ----------------------------------------------------------------------------
module rna_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  rna_pkg::ctl_stat_t st,
	output rna_pkg::ctl_cmd_t  cmd
);
	import rna_pkg::*;

	localparam logic [4:0] CNT_LAST = 5'(DIV_STEPS - 1);

	state_t     state_q;
	state_t     state_nx;
	logic [4:0] cnt_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == S_DIVA || state_q == S_DIVB) begin
			cnt_q <= cnt_q + 5'd1;
		end else begin
			cnt_q <= '0;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_nx = S_DECIDE;
			S_DECIDE: begin
				if (st.early) state_nx = S_FIN;
				else if (st.addsub) state_nx = S_GCD;
				else state_nx = S_MUL0;
			end
			S_GCD:    if (st.gcd_done) state_nx = S_DIVA;
			S_DIVA:   if (cnt_q == CNT_LAST) state_nx = S_DIVSW;
			S_DIVSW:  state_nx = S_DIVB;
			S_DIVB:   if (cnt_q == CNT_LAST) state_nx = S_MUL0;
			S_MUL0:   state_nx = S_MUL1;
			S_MUL1:   state_nx = S_MUL2;
			S_MUL2:   state_nx = S_SUM;
			S_SUM:    state_nx = S_FIN;
			S_FIN:    state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.mul_idx = PR_0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE:  cmd.load = start;
			S_GCD: begin
				cmd.gcd_step = !st.gcd_done;
				cmd.div_init = st.gcd_done;
			end
			S_DIVA:  cmd.div_step = 1'b1;
			S_DIVSW: begin
				cmd.div_init  = 1'b1;
				cmd.div_sel_b = 1'b1;
			end
			S_DIVB:  cmd.div_step = 1'b1;
			S_MUL0: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_idx = PR_0;
			end
			S_MUL1: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_idx = PR_1;
			end
			S_MUL2: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_idx = PR_2;
			end
			S_SUM:   cmd.sum_go = 1'b1;
			S_FIN:   cmd.fin_go = 1'b1;
			default: cmd.load = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/rna_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rna_dpath: datapath of the rational number alu
// Sign-magnitude operand registers, binary gcd, restoring divider, one
// shared 32x32 multiplier, magnitude adder and the result formatter.
// ----------------------------------------------------------------------------
module rna_dpath #(
	parameter int unsigned WIDTH = rna_pkg::WIDTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  rna_pkg::req_t     req,
	input  rna_pkg::ctl_cmd_t cmd,
	output rna_pkg::ctl_stat_t st,
	output logic              done,
	output rna_pkg::rsp_t     rsp
);
	import rna_pkg::*;

	localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);
	localparam int unsigned SH  = 64 - WIDTH;

	// operand registers
	logic [2:0]  cmd_q;
	logic        bad_q, zero_q;
	logic        an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [31:0] an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	// gcd and divider
	logic [31:0] gx_q, gy_q, g_q;
	logic [4:0]  gk_q;
	logic [31:0] rem_q, quo_q, ka_q;
	// products and sum
	logic        p0_neg_q, p1_neg_q, p2_neg_q;
	logic [63:0] p0_mag_q, p1_mag_q, p2_mag_q;
	logic        rn_neg_q;
	logic [63:0] rn_mag_q;
	rsp_t        rsp_q;
	logic        done_q;

	logic        addsub;
	logic [31:0] an_mag_in, ad_mag_in, bn_mag_in, bd_mag_in;
	logic [32:0] div_sh;
	logic        div_ge;
	logic [31:0] f1, f2;
	logic        fs;
	logic [63:0] prod;
	logic        sum_neg;
	logic [63:0] sum_mag;
	logic [1:0]  cmp_res;
	logic        rn_fits, rd_fits;
	logic [63:0] rn_v, rd_v;
	logic signed [63:0] rn_w, rd_w;
	rsp_t        rsp_nx;

	assign addsub = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);

	// input magnitudes
	assign an_mag_in = req.a_num[31] ? (32'd0 - req.a_num) : req.a_num;
	assign ad_mag_in = req.a_den[31] ? (32'd0 - req.a_den) : req.a_den;
	assign bn_mag_in = req.b_num[31] ? (32'd0 - req.b_num) : req.b_num;
	assign bd_mag_in = req.b_den[31] ? (32'd0 - req.b_den) : req.b_den;

	// request capture, subtract flips the sign of b
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= req.cmd;
			bad_q    <= (req.cmd > CMD_CMP);
			zero_q   <= (ad_mag_in == '0) || (bd_mag_in == '0);
			an_neg_q <= req.a_num[31];
			ad_neg_q <= req.a_den[31];
			bn_neg_q <= req.b_num[31] ^ (req.cmd == CMD_SUB);
			bd_neg_q <= req.b_den[31];
			an_mag_q <= an_mag_in;
			ad_mag_q <= ad_mag_in;
			bn_mag_q <= bn_mag_in;
			bd_mag_q <= bd_mag_in;
		end
	end

	// binary gcd of the denominator magnitudes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gx_q <= ad_mag_in;
			gy_q <= bd_mag_in;
			gk_q <= '0;
		end else if (cmd.gcd_step) begin
			priority if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				gk_q <= gk_q + 5'd1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q > gy_q) begin
				gx_q <= (gx_q - gy_q) >> 1;
			end else begin
				gy_q <= (gy_q - gx_q) >> 1;
			end
		end
	end

	// restoring divider, dividend over the gcd
	assign div_sh = {rem_q, quo_q[31]};
	assign div_ge = (div_sh >= {1'b0, g_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= cmd.div_sel_b ? ad_mag_q : bd_mag_q;
			if (cmd.div_sel_b) ka_q <= quo_q;
			else g_q <= gx_q << gk_q;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? 32'(div_sh - {1'b0, g_q}) : div_sh[31:0];
			quo_q <= {quo_q[30:0], div_ge};
		end
	end

	// factor selection for the shared multiplier
	always_comb begin
		f1 = an_mag_q;
		f2 = bd_mag_q;
		fs = an_neg_q ^ bd_neg_q;
		unique case (cmd.mul_idx)
			PR_0: begin
				f1 = an_mag_q;
				if (addsub) begin
					f2 = ka_q;
					fs = an_neg_q ^ bd_neg_q;
				end else if (cmd_q == CMD_MUL) begin
					f2 = bn_mag_q;
					fs = an_neg_q ^ bn_neg_q;
				end else begin
					f2 = bd_mag_q;
					fs = an_neg_q ^ bd_neg_q;
				end
			end
			PR_1: begin
				f1 = bn_mag_q;
				f2 = addsub ? quo_q : ad_mag_q;
				fs = bn_neg_q ^ ad_neg_q;
			end
			PR_2: begin
				f1 = ad_mag_q;
				if (addsub) begin
					f2 = ka_q;
					fs = ad_neg_q ^ bd_neg_q;
				end else if (cmd_q == CMD_MUL) begin
					f2 = bd_mag_q;
					fs = ad_neg_q ^ bd_neg_q;
				end else begin
					f2 = bn_mag_q;
					fs = ad_neg_q ^ bn_neg_q;
				end
			end
			default: begin
				f1 = '0;
				f2 = '0;
				fs = 1'b0;
			end
		endcase
	end

	assign prod = {32'd0, f1} * {32'd0, f2};

	// product registers, zero is positive
	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			unique case (cmd.mul_idx)
				PR_0: begin
					p0_mag_q <= prod;
					p0_neg_q <= fs && (prod != '0);
				end
				PR_1: begin
					p1_mag_q <= prod;
					p1_neg_q <= fs && (prod != '0);
				end
				PR_2: begin
					p2_mag_q <= prod;
					p2_neg_q <= fs && (prod != '0);
				end
				default: p0_mag_q <= p0_mag_q;
			endcase
		end
	end

	// signed magnitude sum of the scaled numerators
	always_comb begin
		if (p0_neg_q == p1_neg_q) begin
			sum_neg = p0_neg_q;
			sum_mag = p0_mag_q + p1_mag_q;
		end else if (p0_mag_q >= p1_mag_q) begin
			sum_neg = p0_neg_q;
			sum_mag = p0_mag_q - p1_mag_q;
		end else begin
			sum_neg = p1_neg_q;
			sum_mag = p1_mag_q - p0_mag_q;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_go) begin
			rn_neg_q <= addsub ? sum_neg : p0_neg_q;
			rn_mag_q <= addsub ? sum_mag : p0_mag_q;
		end
	end

	// exact compare of the cross products
	always_comb begin
		if (p0_neg_q != p1_neg_q) cmp_res = p0_neg_q ? ORD_LT : ORD_GT;
		else if (p0_mag_q == p1_mag_q) cmp_res = ORD_EQ;
		else if (p0_neg_q) cmp_res = (p0_mag_q > p1_mag_q) ? ORD_LT : ORD_GT;
		else cmp_res = (p0_mag_q < p1_mag_q) ? ORD_LT : ORD_GT;
		if (ad_neg_q != bd_neg_q && cmp_res != ORD_EQ) begin
			cmp_res = (cmp_res == ORD_LT) ? ORD_GT : ORD_LT;
		end
	end

	// range check and wrap to WIDTH bits
	always_comb begin
		rn_fits = rn_neg_q ? (rn_mag_q <= LIM) : (rn_mag_q < LIM);
		rd_fits = p2_neg_q ? (p2_mag_q <= LIM) : (p2_mag_q < LIM);
		rn_v = rn_neg_q ? (64'd0 - rn_mag_q) : rn_mag_q;
		rd_v = p2_neg_q ? (64'd0 - p2_mag_q) : p2_mag_q;
		rn_w = $signed(rn_v << SH) >>> SH;
		rd_w = $signed(rd_v << SH) >>> SH;
	end

	// result selection
	always_comb begin
		rsp_nx = '0;
		priority if (bad_q) begin
			rsp_nx = '0;
		end else if (zero_q) begin
			rsp_nx.status = ST_ZERO_DEN;
		end else if (cmd_q == CMD_CMP) begin
			rsp_nx.order = cmp_res;
		end else begin
			rsp_nx.res_num = rn_w[31:0];
			rsp_nx.res_den = rd_w[31:0];
			if (p2_mag_q == '0) rsp_nx.status = ST_ZERO_DEN;
			else if (!rn_fits || !rd_fits) rsp_nx.status = ST_OVF;
			else rsp_nx.status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_go) rsp_q <= rsp_nx;
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin_go;
		end
	end

	assign st.early    = bad_q || zero_q;
	assign st.addsub   = addsub;
	assign st.gcd_done = (gx_q == gy_q);
	assign done        = done_q;
	assign rsp         = rsp_q;

endmodule
`default_nettype wire

FILE: sv/rational_number_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_number_alu: exact arithmetic on two fractions
// Add, subtract, multiply, divide and compare of signed fractions, results
// not reduced, wrapped to WIDTH bits with zero-denominator and overflow flags.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on rsp with done high for exactly one cycle and cannot be held off. Multiply,
// divide and compare pass through the three products, the sum and the result
// stage; a bad command or zero operand denominator goes straight to the result
// stage. Add and subtract first run the binary gcd of the denominators, one
// step per cycle, and two 32-step restoring divisions by that gcd. One 32x32
// multiplier is shared by the three products.
// busy falls in the cycle that done rises, so the next request may be given then.
module rational_number_alu #(
	parameter int unsigned WIDTH = rna_pkg::WIDTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	output logic          busy,
	input  rna_pkg::req_t req,
	output logic          done,
	output rna_pkg::rsp_t rsp
);
	import rna_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t st;

	// sequencer
	rna_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	// arithmetic
	rna_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.done   (done),
		.rsp    (rsp)
	);

	// a request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request");

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a result is shown only once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// compare results of equal or greater carry no fraction
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.order != ORD_LT |-> rsp.res_num == '0 && rsp.res_den == '0)
		else $error("compare result with nonzero fraction");

endmodule
`default_nettype wire

FILE: sim/tb_rational_number_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rational_number_alu: self-checking bench of the rational number alu
// Drives a directed table of fraction requests, then random ones, through the
// start/busy handshake, takes each result from its row or a behavioral model
// and compares it field by field against the done-strobed result.
// ----------------------------------------------------------------------------
module tb_rational_number_alu;
	import rna_pkg::*;

	localparam int unsigned W = WIDTH_DEF;
	localparam int N_RANDOM = 700;
	localparam int STALL_LIMIT = 5000;

	// directed row: request, whether a typed-in result is given, that result
	typedef struct {
		req_t req;
		bit   typed;
		rsp_t rsp;
	} row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  rsp;

	rsp_t  pending_q[$];
	row_t  rows[$];
	int    n_err;
	int    n_sent;
	int    n_recv;
	int    idle_cycles;
	int    n_zden;
	int    n_ovf;
	int    n_cmp;

	rational_number_alu #(.WIDTH(W)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// wrap an exact value to W bits, sign extended, low 32 kept
	function automatic logic [31:0] wrap_w(logic signed [127:0] v);
		logic signed [127:0] t;
		t = v <<< (128 - W);
		t = t >>> (128 - W);
		return t[31:0];
	endfunction

	function automatic bit fits_w(logic signed [127:0] v);
		logic signed [127:0] lim;
		lim = 128'sd1 <<< (W - 1);
		return (v < lim) && (v >= -lim);
	endfunction

	// gcd of magnitudes
	function automatic logic [63:0] gcd_mag(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// fraction arithmetic predictor
	function automatic rsp_t fraction_result(req_t r);
		rsp_t o;
		logic signed [127:0] an, ad, bn, bd, rn, rd, g, ka, kb, l, rr;
		o = '0;
		an = r.a_num; ad = r.a_den; bn = r.b_num; bd = r.b_den;
		if (r.cmd > CMD_CMP)
			return o;
		if (ad == 0 || bd == 0) begin
			o.status = ST_ZERO_DEN;
			return o;
		end
		if (r.cmd == CMD_CMP) begin
			l = an * bd;
			rr = bn * ad;
			if ((ad < 0) != (bd < 0)) begin
				l = -l;
				rr = -rr;
			end
			o.order = (l < rr) ? ORD_LT : (l == rr) ? ORD_EQ : ORD_GT;
			return o;
		end
		case (r.cmd)
			CMD_ADD, CMD_SUB: begin
				g = $signed({64'd0, gcd_mag(64'(ad < 0 ? -ad : ad),
					64'(bd < 0 ? -bd : bd))});
				ka = bd / g;
				kb = ad / g;
				rd = ad * ka;
				rn = (r.cmd == CMD_SUB) ? an * ka - bn * kb : an * ka + bn * kb;
			end
			CMD_MUL: begin
				rn = an * bn;
				rd = ad * bd;
			end
			default: begin
				rn = an * bd;
				rd = ad * bn;
			end
		endcase
		o.res_num = wrap_w(rn);
		o.res_den = wrap_w(rd);
		if (rd == 0)
			o.status = ST_ZERO_DEN;
		else if (!fits_w(rn) || !fits_w(rd))
			o.status = ST_OVF;
		return o;
	endfunction

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 20) - 10;
			3: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_den();
		logic [31:0] v;
		if ($urandom_range(0, 39) == 0)
			return 32'd0;
		v = rand_field();
		return (v == 0) ? 32'd7 : v;
	endfunction

	function automatic row_t make_row(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd, bit typed, rsp_t e);
		row_t x;
		x.req = '{cmd: c, a_num: an, a_den: ad, b_num: bn, b_den: bd};
		x.typed = typed;
		x.rsp = e;
		return x;
	endfunction

	// hand one request over, with random gaps outside the quiet stretch
	task automatic send_request(req_t r, bit quiet);
		if (!quiet && $urandom_range(0, 99) < 38) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 38)
				@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		n_sent++;
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			n_recv++;
			if (pending_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected result %h", rsp);
			end else begin
				want = pending_q.pop_front();
				if (rsp.res_num !== want.res_num || rsp.res_den !== want.res_den ||
					rsp.order !== want.order || rsp.status !== want.status) begin
					n_err++;
					if (n_err <= 10) begin
						$display("mismatch #%0d: exp num %h den %h ord %0d st %0d",
							n_recv, want.res_num, want.res_den, want.order,
							want.status);
						$display("  got num %h den %h ord %0d st %0d",
							rsp.res_num, rsp.res_den, rsp.order, rsp.status);
					end
				end
			end
		end
	end

	// watchdog on cycles with no request or result accepted
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		rsp_t zd, z;
		req_t r;
		rsp_t e;
		int   drain;
		zd = '0;
		zd.status = ST_ZERO_DEN;
		z = '0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		n_err = 0; n_sent = 0; n_recv = 0; idle_cycles = 0;
		n_zden = 0; n_ovf = 0; n_cmp = 0;

		// directed table
		rows.push_back(make_row(CMD_ADD, 1, 2, 1, 3, 0, z));
		rows.push_back(make_row(CMD_SUB, 1, 2, 1, 3, 0, z));
		rows.push_back(make_row(CMD_MUL, -3, 4, 5, -7, 0, z));
		rows.push_back(make_row(CMD_DIV, 3, 4, 5, 7, 0, z));
		rows.push_back(make_row(CMD_CMP, 1, 2, 2, 4, 1, '{0, 0, ORD_EQ, ST_OK}));
		rows.push_back(make_row(CMD_CMP, 1, 3, 1, 2, 1, '{0, 0, ORD_LT, ST_OK}));
		rows.push_back(make_row(CMD_CMP, 1, -2, -1, 3, 0, z));
		rows.push_back(make_row(CMD_ADD, 5, 0, 1, 1, 1, zd));
		rows.push_back(make_row(CMD_DIV, 1, 1, 1, 0, 1, zd));
		rows.push_back(make_row(CMD_CMP, 1, 0, 1, 0, 1, zd));
		rows.push_back(make_row(CMD_DIV, 3, 5, 0, 2, 0, z));
		rows.push_back(make_row(3'd5, 1, 2, 3, 4, 1, z));
		rows.push_back(make_row(3'd7, -1, -1, -1, -1, 1, z));
		rows.push_back(make_row(CMD_MUL, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 0, z));
		rows.push_back(make_row(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 0, z));
		rows.push_back(make_row(CMD_SUB, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 0, z));
		rows.push_back(make_row(CMD_ADD, -6, -4, 3, 6, 0, z));
		rows.push_back(make_row(CMD_CMP, 32'h8000_0000, 1, 32'h7fff_ffff, 1, 1,
			'{0, 0, ORD_LT, ST_OK}));
		rows.push_back(make_row(CMD_DIV, 32'h7fff_ffff, -1, 32'h8000_0000, 32'h7fff_ffff, 0, z));
		rows.push_back(make_row(CMD_ADD, 0, 1, 0, -1, 0, z));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			e = rows[i].typed ? rows[i].rsp : fraction_result(rows[i].req);
			pending_q.push_back(e);
			send_request(rows[i].req, 0);
		end

		// random part; a quiet stretch with no gaps in the middle
		for (int i = 0; i < N_RANDOM; i++) begin
			r.cmd = 3'(($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) :
				$urandom_range(0, 4));
			r.a_num = rand_field();
			r.b_num = rand_field();
			r.a_den = rand_den();
			r.b_den = rand_den();
			e = fraction_result(r);
			if (e.status == ST_ZERO_DEN) n_zden++;
			if (e.status == ST_OVF) n_ovf++;
			if (r.cmd == CMD_CMP) n_cmp++;
			pending_q.push_back(e);
			send_request(r, i >= 250 && i < 350);
		end
		start <= 1'b0;

		// drain
		drain = 0;
		while (pending_q.size() != 0 && drain < STALL_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (200) @(posedge clk);

		$display("sent %0d requests (%0d table rows), %0d results checked", n_sent,
			rows.size(), n_recv);
		$display("random mix: %0d zero-denominator, %0d overflow, %0d compare", n_zden,
			n_ovf, n_cmp);
		if (n_err == 0 && pending_q.size() == 0)
			$display("SUCCESS");
		else begin
			$display("%0d mismatches, %0d results missing", n_err, pending_q.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire
